/* src/bfa_pkg.sv */
// shared types and constants of the bitmap frame allocator
package bfa_pkg;

  // fixed field widths
  localparam int ADDR_W    = 24;
  localparam int RES_W     = 25;
  localparam int CNT_W     = 13;
  // width of the page divider dividend: holds reserved end plus page size minus one
  localparam int DIV_W     = RES_W + 1;
  // bitmap word geometry
  localparam int WORD_BITS = 32;
  localparam int BIT_SEL_W = 5;

  // request opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // request beat
  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  // result beat
  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic [1:0]        status;
    logic [CNT_W-1:0]  used_frames;
    logic [CNT_W-1:0]  free_frames;
  } resp_t;

  // controller to datapath commands
  typedef struct packed {
    logic       div_go;
    logic       div_init;
    logic       load_n;
    logic       sweep_begin;
    logic       sweep_step;
    logic       init_commit;
    logic       scan_begin;
    logic       scan_read;
    logic       scan_hit;
    logic       scan_next;
    logic       free_read;
    logic       free_apply;
    logic       emit;
    logic       emit_alloc;
    logic [1:0] emit_status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic free_oor;
    logic hint_full;
    logic scan_found;
    logic scan_last;
  } stat_t;

endpackage

/* src/bitmap_frame_allocator_top.sv */
// top level of the bitmap page frame allocator
//
// Requests are taken on start while busy is low: allocate (first fit from the
// low-water hint), free (by byte address), or init (clear the map and mark the
// frames below reserved_end, rounded up to a page, as used). Each request
// gives exactly one result beat on resp, valid for the single cycle in which
// done is high; the receiver cannot stall, so results are never held back.
// reserved_end is written by the user through cfg_we / cfg_data while the block
// is idle, which the block does not enforce. Steps from accept to the result:
//   allocate: one read and one check per word from the hint word on,
//             straight to the result when the hint already sits past the map
//   free:     page index shift (PAGE_BYTES a power of two), then read and
//             bit clear; straight to the result for an address beyond the map
//   init:     page count through the shift, then a word-per-cycle sweep
//   unused opcode: straight to the result
// A new request can be accepted in the cycle its predecessor's done is high.
// The map sits in one single-port-write, registered-read memory; the scan
// reads and checks one 32-frame word at a time.
// After reset busy stays high while the map is swept clear word by word;
// configuration writes are taken during that pass.
module bitmap_frame_allocator_top import bfa_pkg::*; #(
  parameter int FRAME_COUNT = 4096,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output resp_t            resp,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  bfa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (req.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // map and arithmetic
  bfa_datapath #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .free_address (req.free_address),
    .cmd          (cmd),
    .stat         (stat),
    .resp         (resp),
    .done         (done)
  );

endmodule

/* src/bfa_div.sv */
// page index unit: division by the power-of-two page size as a registered shift
module bfa_div import bfa_pkg::*; #(
  parameter int DIVISOR = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [DIV_W-1:0] dividend,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  localparam int SHIFT = $clog2(DIVISOR);

  // quotient captured on go and held until the next go
  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend >> SHIFT;
    end
  end

  // done is go registered, high in the cycle after go
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= go;
    end
  end

endmodule

/* src/bfa_datapath.sv */
// bitmap memory, search logic, counters and result register
module bfa_datapath import bfa_pkg::*; #(
  parameter int FRAME_COUNT = 4096,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0] free_address,
  input  cmd_t             cmd,
  output stat_t            stat,
  output resp_t            resp,
  output logic             done
);

  localparam int FW        = $clog2(FRAME_COUNT + 1);
  localparam int IW        = $clog2(FRAME_COUNT);
  localparam int WORDS     = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LAST_BITS = FRAME_COUNT - (WORDS - 1) * WORD_BITS;
  localparam int PROD_W    = FW + $clog2(PAGE_BYTES) + 1;
  localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [WAW-1:0]       wptr;
  logic [FW-1:0]        n_reg;
  logic [FW-1:0]        hint;
  logic [FW-1:0]        used_total;
  logic [ADDR_W-1:0]    alloc_addr;
  logic [RES_W-1:0]     reserved_end;

  logic [DIV_W-1:0]     div_dividend;
  logic [DIV_W-1:0]     quotient;
  logic                 div_done;

  logic [WAW-1:0]       hint_word;
  logic [BIT_SEL_W-1:0] hint_bit;
  logic                 at_last;
  logic [WORD_BITS-1:0] eligible;
  logic [BIT_SEL_W-1:0] pos;
  logic [FW-1:0]        hit_frame;
  logic [PROD_W-1:0]    hit_prod;
  logic [FW-1:0]        nw;
  logic [BIT_SEL_W-1:0] nb;
  logic [WORD_BITS-1:0] pattern;
  logic [IW-1:0]        qidx;
  logic [WAW-1:0]       free_word;
  logic [BIT_SEL_W-1:0] free_bit;
  logic                 q_oor;
  logic                 mem_we;
  logic [WAW-1:0]       waddr;
  logic [WAW-1:0]       raddr;
  logic [WORD_BITS-1:0] wdata;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_end <= '0;
    end else if (cfg_we) begin
      reserved_end <= cfg_data;
    end
  end

  // page divider, rounds up for init
  assign div_dividend = cmd.div_init
    ? (DIV_W'(reserved_end) + DIV_W'(PAGE_BYTES - 1))
    : DIV_W'(free_address);

  bfa_div #(
    .DIVISOR (PAGE_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_dividend),
    .quotient (quotient),
    .done     (div_done)
  );

  // first-fit search within the current word
  always_comb begin
    hint_word = WAW'(hint >> BIT_SEL_W);
    hint_bit  = BIT_SEL_W'(hint);
    at_last   = (wptr == WAW'(WORDS - 1));
    eligible  = ~rd_data
              & (at_last ? LAST_MASK : {WORD_BITS{1'b1}})
              & ((wptr == hint_word) ? ({WORD_BITS{1'b1}} << hint_bit) : {WORD_BITS{1'b1}});
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (eligible[i]) begin
        pos = BIT_SEL_W'(i);
      end
    end
    hit_frame = (FW'(wptr) << BIT_SEL_W) | FW'(pos);
    hit_prod  = PROD_W'(hit_frame) * PROD_W'(PAGE_BYTES);
  end

  // reservation pattern of the word under the sweep pointer
  always_comb begin
    nw = n_reg >> BIT_SEL_W;
    nb = BIT_SEL_W'(n_reg);
    if (FW'(wptr) < nw) begin
      pattern = {WORD_BITS{1'b1}};
    end else if (FW'(wptr) == nw) begin
      pattern = ~({WORD_BITS{1'b1}} << nb);
    end else begin
      pattern = '0;
    end
  end

  // frame selected by a free
  always_comb begin
    qidx      = IW'(quotient);
    free_word = WAW'(qidx >> BIT_SEL_W);
    free_bit  = BIT_SEL_W'(qidx);
    q_oor     = (quotient >= DIV_W'(FRAME_COUNT));
  end

  // memory port selection
  always_comb begin
    mem_we = cmd.sweep_step | cmd.scan_hit | cmd.free_apply;
    waddr  = cmd.free_apply ? free_word : wptr;
    raddr  = cmd.free_read ? free_word : wptr;
    if (cmd.sweep_step) begin
      wdata = pattern;
    end else if (cmd.scan_hit) begin
      wdata = rd_data | (WORD_BITS'(1) << pos);
    end else begin
      wdata = rd_data & ~(WORD_BITS'(1) << free_bit);
    end
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // word pointer, hint, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      n_reg      <= '0;
      hint       <= '0;
      used_total <= '0;
    end else begin
      if (cmd.load_n) begin
        n_reg <= q_oor ? FW'(FRAME_COUNT) : FW'(quotient);
      end
      if (cmd.sweep_begin) begin
        wptr <= '0;
      end else if (cmd.scan_begin) begin
        wptr <= hint_word;
      end else if (cmd.sweep_step || cmd.scan_next) begin
        wptr <= wptr + 1'b1;
      end
      if (cmd.init_commit) begin
        hint       <= n_reg;
        used_total <= n_reg;
      end
      if (cmd.scan_hit) begin
        hint       <= hit_frame + 1'b1;
        used_total <= used_total + 1'b1;
      end
      if (cmd.free_apply) begin
        if (rd_data[free_bit]) begin
          used_total <= used_total - 1'b1;
        end
        if (FW'(qidx) < hint) begin
          hint <= FW'(qidx);
        end
      end
    end
  end

  // address of the frame just allocated
  always_ff @(posedge clk) begin
    if (cmd.scan_hit) begin
      alloc_addr <= ADDR_W'(hit_prod);
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      resp.frame_address <= cmd.emit_alloc ? alloc_addr : '0;
      resp.status        <= cmd.emit_status;
      resp.used_frames   <= CNT_W'(used_total);
      resp.free_frames   <= CNT_W'(FW'(FRAME_COUNT) - used_total);
    end
  end

  // status to the controller
  assign stat.div_done   = div_done;
  assign stat.free_oor   = q_oor;
  assign stat.hint_full  = (hint >= FW'(FRAME_COUNT));
  assign stat.scan_found = |eligible;
  assign stat.scan_last  = at_last;

`ifndef ASSERT_OFF
  // no result strobe follows directly on another
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobes back to back");
  // counts in a result add up to the map size
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (resp.used_frames + resp.free_frames) == CNT_W'(FRAME_COUNT))
    else $error("used and free counts disagree");
  // used count never passes the map size
  a_used_max: assert property (@(posedge clk) disable iff (rst)
    used_total <= FW'(FRAME_COUNT))
    else $error("used count overflow");
  // a hit always lands on a frame at or above the hint and inside the map
  a_hit_hint: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_hit |-> hit_frame >= hint && hit_frame < FW'(FRAME_COUNT))
    else $error("allocation below hint or past map");
`endif

endmodule

/* src/bfa_ctrl.sv */
// request sequencer of the bitmap frame allocator
module bfa_ctrl import bfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] opcode,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_A_RD  = 9'b000000100,
    S_A_CHK = 9'b000001000,
    S_DIV_F = 9'b000010000,
    S_F_CHK = 9'b000100000,
    S_DIV_I = 9'b001000000,
    S_SWEEP = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] res_status, res_status_next;
  logic       res_alloc, res_alloc_next;

  // next state and commands
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_alloc_next  = res_alloc;
    cmd             = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          res_alloc_next  = 1'b0;
          res_status_next = ST_OK;
          unique case (opcode)
            OP_ALLOC: begin
              if (stat.hint_full) begin
                res_status_next = ST_OOM;
                state_next      = S_RESP;
              end else begin
                cmd.scan_begin = 1'b1;
                state_next     = S_A_RD;
              end
            end
            OP_FREE: begin
              cmd.div_go = 1'b1;
              state_next = S_DIV_F;
            end
            OP_INIT: begin
              cmd.div_go   = 1'b1;
              cmd.div_init = 1'b1;
              state_next   = S_DIV_I;
            end
            OP_NONE: begin
              state_next = S_RESP;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_A_RD: begin
        cmd.scan_read = 1'b1;
        state_next    = S_A_CHK;
      end
      S_A_CHK: begin
        if (stat.scan_found) begin
          cmd.scan_hit   = 1'b1;
          res_alloc_next = 1'b1;
          state_next     = S_RESP;
        end else if (stat.scan_last) begin
          res_status_next = ST_OOM;
          state_next      = S_RESP;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_A_RD;
        end
      end
      S_DIV_F: begin
        if (stat.div_done) begin
          if (stat.free_oor) begin
            res_status_next = ST_RANGE;
            state_next      = S_RESP;
          end else begin
            cmd.free_read = 1'b1;
            state_next    = S_F_CHK;
          end
        end
      end
      S_F_CHK: begin
        cmd.free_apply = 1'b1;
        state_next     = S_RESP;
      end
      S_DIV_I: begin
        if (stat.div_done) begin
          cmd.load_n      = 1'b1;
          cmd.sweep_begin = 1'b1;
          state_next      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.scan_last) begin
          cmd.init_commit = 1'b1;
          state_next      = S_RESP;
        end
      end
      S_RESP: begin
        cmd.emit        = 1'b1;
        cmd.emit_alloc  = res_alloc;
        cmd.emit_status = res_status;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      res_status <= ST_OK;
      res_alloc  <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_alloc  <= res_alloc_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
